[rtl/size_class_buffer_pool_assert.svh]
// Assertion macros shared by the size class buffer pool modules.
`ifndef SIZE_CLASS_BUFFER_POOL_ASSERT_SVH
`define SIZE_CLASS_BUFFER_POOL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/scbp_pkg.sv]
// Types, codes and constants of the size class buffer pool.
package scbp_pkg;

    localparam int DEF_SLOT_COUNT  = 8;
    localparam int DEF_USAGE_TYPES = 8;

    localparam int IN_DATA_W   = 48;
    localparam int IN_USER_W   = 2;
    localparam int OUT_FIELD_W = 163;
    localparam int OUT_DATA_W  = 168;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] RST_SLOT_CLASSES = 16'h9500;
    localparam logic [15:0] RST_SMALL_BYTES  = 16'd256;
    localparam logic [15:0] RST_MEDIUM_BYTES = 16'd512;
    localparam logic [15:0] RST_LARGE_BYTES  = 16'd1024;

    typedef enum logic [1:0] {
        CFG_SLOT_CLASSES = 2'd0,
        CFG_SMALL_BYTES  = 2'd1,
        CFG_MEDIUM_BYTES = 2'd2,
        CFG_LARGE_BYTES  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_STATS = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID_ARG = 2'd1,
        ST_NO_FIT      = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CLS_SMALL   = 2'd0,
        CLS_MEDIUM  = 2'd1,
        CLS_LARGE   = 2'd2,
        CLS_INVALID = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic report;
    } t_cmd;

endpackage

[rtl/scbp_ctrl.sv]
// Controller state machine: stream handshakes and datapath sequencing.
`include "size_class_buffer_pool_assert.svh"

module scbp_ctrl import scbp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:   n_state = S_REPORT;
            S_REPORT: n_state = S_OUT;
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_EXEC:   o_cmd.exec = 1'b1;
            S_REPORT: o_cmd.report = 1'b1;
            S_OUT:    o_m_tvalid = 1'b1;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    `SCBP_ASSERT_NXT(a_capture_to_exec, o_cmd.capture, r_state == S_EXEC, "capture not followed by exec")
    `SCBP_ASSERT_IMP(a_one_side_open, o_s_tready, !o_m_tvalid, "input and output open together")
    `SCBP_ASSERT_NXT(a_exec_to_report, o_cmd.exec, o_cmd.report, "exec not followed by report")

endmodule

[rtl/scbp_dpath.sv]
// Datapath: slot table, id counter, statistics and the result register.
`include "size_class_buffer_pool_assert.svh"

module scbp_dpath import scbp_pkg::*; #(
    parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
    parameter int USAGE_TYPES = DEF_USAGE_TYPES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int USE_W  = (USAGE_TYPES > 1) ? $clog2(USAGE_TYPES) : 1;

    // Configuration registers.
    logic [15:0] r_slot_classes;
    logic [15:0] r_small_bytes;
    logic [15:0] r_medium_bytes;
    logic [15:0] r_large_bytes;

    // Captured request.
    t_action     r_act;
    logic [1:0]  r_want;
    logic [3:0]  r_usage;
    logic [2:0]  r_slot;
    logic [31:0] r_id;

    // Pool state.
    logic [SLOT_COUNT-1:0] r_slot_busy;
    logic [31:0]           r_slot_ids [SLOT_COUNT];
    logic [31:0]           r_next_id;
    logic [31:0]           r_alloc_total;
    logic [31:0]           r_alloc_fail;
    logic [CNT_W-1:0]      r_busy_cnt;
    logic [CNT_W-1:0]      r_busy_peak;
    logic [31:0]           r_tally [USAGE_TYPES];

    // Per-item results of the execute step.
    t_status     r_status;
    logic [2:0]  r_g_slot;
    logic [1:0]  r_g_class;
    logic [15:0] r_g_bytes;
    logic [31:0] r_g_id;

    logic [OUT_DATA_W-1:0] r_out;

    logic [1:0]            w_cls [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] w_fit;
    logic                  w_found;
    logic [SLOT_W-1:0]     w_found_idx;
    logic [CNT_W-1:0]      w_fit_cnt;
    logic                  w_want_bad;
    logic                  w_free_in_range;
    logic [SLOT_W-1:0]     w_free_idx;
    logic                  w_id_match;
    logic                  w_use_in_range;
    logic [USE_W-1:0]      w_use_idx;
    logic [31:0]           w_id_inc;
    logic [CNT_W-1:0]      w_busy_inc;
    logic [15:0]           w_found_bytes;
    logic [3:0]            w_free_out;
    logic [31:0]           w_usage_out;

    // A class code of three counts as large; slots past eight reuse the fields.
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_cls[i] = r_slot_classes[(i % 8) * 2 +: 2];
            if (w_cls[i] == CLS_INVALID) begin
                w_cls[i] = CLS_LARGE;
            end
            w_fit[i] = !r_slot_busy[i] && (w_cls[i] >= r_want);
        end
    end

    always_comb begin
        w_found     = 1'b0;
        w_found_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (w_fit[i] && !w_found) begin
                w_found     = 1'b1;
                w_found_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        w_fit_cnt = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_fit_cnt = w_fit_cnt + CNT_W'(w_fit[i]);
        end
    end

    always_comb begin
        case (w_cls[w_found_idx])
            CLS_SMALL:  w_found_bytes = r_small_bytes;
            CLS_MEDIUM: w_found_bytes = r_medium_bytes;
            default:    w_found_bytes = r_large_bytes;
        endcase
    end

    assign w_want_bad      = (r_want == CLS_INVALID);
    assign w_free_in_range = (int'(r_slot) < SLOT_COUNT);
    assign w_free_idx      = SLOT_W'(r_slot);
    assign w_id_match      = w_free_in_range && (r_slot_ids[w_free_idx] == r_id);
    assign w_use_in_range  = (int'(r_usage) < USAGE_TYPES);
    assign w_use_idx       = USE_W'(r_usage);
    assign w_id_inc        = r_next_id + 32'd1;
    assign w_busy_inc      = r_busy_cnt + CNT_W'(1);
    assign w_free_out      = w_want_bad ? 4'd0 : 4'(w_fit_cnt);
    assign w_usage_out     = w_use_in_range ? r_tally[w_use_idx] : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_classes <= RST_SLOT_CLASSES;
            r_small_bytes  <= RST_SMALL_BYTES;
            r_medium_bytes <= RST_MEDIUM_BYTES;
            r_large_bytes  <= RST_LARGE_BYTES;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SLOT_CLASSES: r_slot_classes <= i_cfg_wdata;
                CFG_SMALL_BYTES:  r_small_bytes  <= i_cfg_wdata;
                CFG_MEDIUM_BYTES: r_medium_bytes <= i_cfg_wdata;
                CFG_LARGE_BYTES:  r_large_bytes  <= i_cfg_wdata;
                default:          r_large_bytes  <= r_large_bytes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act   <= t_action'(i_s_tuser);
            r_want  <= i_s_tdata[1:0];
            r_usage <= i_s_tdata[5:2];
            r_slot  <= i_s_tdata[8:6];
            r_id    <= i_s_tdata[40:9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_busy   <= '0;
            r_next_id     <= 32'd1;
            r_alloc_total <= '0;
            r_alloc_fail  <= '0;
            r_busy_cnt    <= '0;
            r_busy_peak   <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_ids[i] <= '0;
            end
            for (int u = 0; u < USAGE_TYPES; u++) begin
                r_tally[u] <= '0;
            end
        end else if (i_cmd.exec) begin
            case (r_act)
                ACT_ALLOC: begin
                    if (!w_want_bad && !w_found) begin
                        r_alloc_fail <= r_alloc_fail + 32'd1;
                    end else if (!w_want_bad) begin
                        r_slot_busy[w_found_idx] <= 1'b1;
                        r_slot_ids[w_found_idx]  <= r_next_id;
                        // Id zero marks a free slot, so the counter skips it.
                        r_next_id     <= (w_id_inc == 32'd0) ? 32'd1 : w_id_inc;
                        r_alloc_total <= r_alloc_total + 32'd1;
                        r_busy_cnt    <= w_busy_inc;
                        if (w_busy_inc > r_busy_peak) begin
                            r_busy_peak <= w_busy_inc;
                        end
                        if (w_use_in_range) begin
                            r_tally[w_use_idx] <= r_tally[w_use_idx] + 32'd1;
                        end
                    end
                end
                ACT_FREE: begin
                    if (w_id_match && r_slot_busy[w_free_idx]) begin
                        r_slot_busy[w_free_idx] <= 1'b0;
                        r_slot_ids[w_free_idx]  <= '0;
                        if (r_busy_cnt != '0) begin
                            r_busy_cnt <= r_busy_cnt - CNT_W'(1);
                        end
                    end
                end
                ACT_STATS: begin
                    r_alloc_total <= '0;
                    r_alloc_fail  <= '0;
                    r_busy_peak   <= r_busy_cnt;
                    for (int u = 0; u < USAGE_TYPES; u++) begin
                        r_tally[u] <= '0;
                    end
                end
                default: begin
                    r_busy_peak <= r_busy_peak;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status  <= ST_OK;
            r_g_slot  <= '0;
            r_g_class <= '0;
            r_g_bytes <= '0;
            r_g_id    <= '0;
            case (r_act)
                ACT_ALLOC: begin
                    if (w_want_bad) begin
                        r_status <= ST_INVALID_ARG;
                    end else if (!w_found) begin
                        r_status <= ST_NO_FIT;
                    end else begin
                        r_g_slot  <= 3'(w_found_idx);
                        r_g_class <= w_cls[w_found_idx];
                        r_g_bytes <= w_found_bytes;
                        r_g_id    <= r_next_id;
                    end
                end
                ACT_FREE: begin
                    if (!w_id_match) begin
                        r_status <= ST_INVALID_ARG;
                    end else if (!r_slot_busy[w_free_idx]) begin
                        r_status <= ST_DOUBLE_FREE;
                    end
                end
                ACT_COUNT: begin
                    if (w_want_bad) begin
                        r_status <= ST_INVALID_ARG;
                    end
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end
    end

    // The report step reads the state as the execute step left it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_out <= {(OUT_DATA_W - OUT_FIELD_W)'(0),
                      w_usage_out,
                      4'(r_busy_peak),
                      4'(r_busy_cnt),
                      r_alloc_fail,
                      r_alloc_total,
                      w_free_out,
                      r_g_id,
                      r_g_bytes,
                      r_g_class,
                      r_g_slot,
                      r_status};
        end
    end

    assign o_m_tdata = r_out;

    `SCBP_ASSERT_IMP(a_busy_cnt_matches, 1'b1, int'(r_busy_cnt) == $countones(r_slot_busy), "in-use count differs from busy slots")
    `SCBP_ASSERT_IMP(a_peak_covers_cnt, 1'b1, r_busy_peak >= r_busy_cnt, "peak below in-use count")
    `SCBP_ASSERT_IMP(a_next_id_nonzero, 1'b1, r_next_id != 32'd0, "next id is zero")

endmodule

[rtl/size_class_buffer_pool.sv]
// The result beat goes valid once the accepted request beat has passed the
// execute and report states. One request at a time, in order: capture,
// execute against the slot table, report counts from the updated state,
// hand over. The output register holds the result until the consumer takes
// it. Synchronous active-low reset empties all slots, clears statistics,
// sets the next id to one and restores the default slot classes and byte
// sizes.
module size_class_buffer_pool import scbp_pkg::*; #(
    parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
    parameter int USAGE_TYPES = DEF_USAGE_TYPES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata from bit 0: size_class[1:0], usage_tag[5:2], slot_index[8:6],
    // alloc_id[40:9], zero padding up to bit 47.
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: action[1:0].
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    // Result channel.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata from bit 0: status[1:0], granted_slot[4:2], granted_class[6:5],
    // buffer_bytes[22:7], granted_id[54:23], free_count[58:55],
    // total_allocs[90:59], failed_allocs[122:91], in_use_count[126:123],
    // peak_in_use[130:127], usage_count[162:131], zero padding to bit 167.
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // Configuration writes: 0 slot classes, 1 small, 2 medium, 3 large bytes.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Command group from the controller; it is the only link between the
    // sequencing and the pool state.
    t_cmd w_cmd;

    scbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the slot table, ids, counters and the result beat.
    scbp_dpath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .USAGE_TYPES (USAGE_TYPES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

[tb/tb_size_class_buffer_pool.sv]
// Self-checking testbench for the size class buffer pool with directed and random request beats.
`timescale 1ns / 100ps

module tb_size_class_buffer_pool;
    import scbp_pkg::*;

    localparam int NSLOTS       = DEF_SLOT_COUNT;
    localparam int NUSAGE       = DEF_USAGE_TYPES;
    localparam int PHASE_ITEMS  = 282;
    localparam int HOLD_CYCLES  = 150;
    localparam int LIMIT_CYCLES = 100000;
    localparam int REPORT_CAP   = 200;

    // One request as the sender sees it, before packing into tdata and tuser.
    typedef struct {
        t_action     action;
        t_class      want;
        logic [3:0]  usage;
        logic [2:0]  slot;
        logic [31:0] id;
    } pool_request_t;

    // Result beat layout, most significant field first so that the struct
    // overlays o_m_tdata directly.
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] usage_count;
        logic [3:0]  peak_in_use;
        logic [3:0]  in_use_count;
        logic [31:0] failed_allocs;
        logic [31:0] total_allocs;
        logic [3:0]  free_count;
        logic [31:0] granted_id;
        logic [15:0] buffer_bytes;
        logic [1:0]  granted_class;
        logic [2:0]  granted_slot;
        logic [1:0]  status;
    } pool_result_t;

    // Shadow copy of the pool: slot table, statistics and register values.
    // Every accepted request updates it and queues the result the block owes.
    class pool_predictor;
        logic [15:0]  class_map    = RST_SLOT_CLASSES;
        logic [15:0]  small_bytes  = RST_SMALL_BYTES;
        logic [15:0]  medium_bytes = RST_MEDIUM_BYTES;
        logic [15:0]  large_bytes  = RST_LARGE_BYTES;
        bit           slot_busy[NSLOTS];
        bit [31:0]    slot_id[NSLOTS];
        bit [31:0]    next_id = 1;
        bit [31:0]    total;
        bit [31:0]    failures;
        bit [3:0]     busy_cnt;
        bit [3:0]     busy_peak;
        bit [31:0]    usage_tally[NUSAGE];
        pool_result_t results_due[$];
        int           errors;

        function void write_reg(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_SLOT_CLASSES: class_map = value;
                CFG_SMALL_BYTES:  small_bytes = value;
                CFG_MEDIUM_BYTES: medium_bytes = value;
                default:          large_bytes = value;
            endcase
        endfunction

        // A class field of three counts as large.
        function logic [1:0] class_of(int s);
            logic [1:0] c;
            c = class_map[2 * (s % 8) +: 2];
            return (c == CLS_INVALID) ? CLS_LARGE : c;
        endfunction

        function logic [15:0] bytes_of(logic [1:0] c);
            if (c == CLS_SMALL)
                return small_bytes;
            if (c == CLS_MEDIUM)
                return medium_bytes;
            return large_bytes;
        endfunction

        function logic [3:0] fitting(logic [1:0] want);
            int n = 0;
            if (want == CLS_INVALID)
                return 4'd0;
            for (int s = 0; s < NSLOTS; s++)
                if (!slot_busy[s] && class_of(s) >= want)
                    n++;
            return 4'(n);
        endfunction

        function void note_request(pool_request_t req);
            pool_result_t r;
            int found;
            r = '0;
            found = -1;
            case (req.action)
                ACT_ALLOC: begin
                    if (req.want == CLS_INVALID) begin
                        r.status = ST_INVALID_ARG;
                    end else begin
                        for (int s = 0; s < NSLOTS && found < 0; s++)
                            if (!slot_busy[s] && class_of(s) >= req.want)
                                found = s;
                        if (found < 0) begin
                            r.status = ST_NO_FIT;
                            failures++;
                        end else begin
                            slot_busy[found] = 1'b1;
                            slot_id[found] = next_id;
                            r.granted_slot = 3'(found);
                            r.granted_class = class_of(found);
                            r.buffer_bytes = bytes_of(r.granted_class);
                            r.granted_id = next_id;
                            // Zero is never handed out as an id.
                            next_id++;
                            if (next_id == 0)
                                next_id = 1;
                            total++;
                            busy_cnt++;
                            if (busy_cnt > busy_peak)
                                busy_peak = busy_cnt;
                            if (req.usage < NUSAGE)
                                usage_tally[req.usage]++;
                        end
                    end
                end
                ACT_FREE: begin
                    if (req.slot >= NSLOTS || slot_id[req.slot] != req.id) begin
                        r.status = ST_INVALID_ARG;
                    end else if (!slot_busy[req.slot]) begin
                        r.status = ST_DOUBLE_FREE;
                    end else begin
                        slot_busy[req.slot] = 1'b0;
                        slot_id[req.slot] = '0;
                        if (busy_cnt != 0)
                            busy_cnt--;
                    end
                end
                ACT_COUNT: begin
                    if (req.want == CLS_INVALID)
                        r.status = ST_INVALID_ARG;
                end
                default: begin
                    total = '0;
                    failures = '0;
                    foreach (usage_tally[u])
                        usage_tally[u] = '0;
                    busy_peak = busy_cnt;
                end
            endcase
            r.free_count = fitting(req.want);
            r.total_allocs = total;
            r.failed_allocs = failures;
            r.in_use_count = busy_cnt;
            r.peak_in_use = busy_peak;
            r.usage_count = (req.usage < NUSAGE) ? usage_tally[req.usage] : '0;
            results_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            pool_result_t got;
            pool_result_t want;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, actual 0x%0h", $time, data);
                return;
            end
            got = data;
            want = results_due.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("granted_slot", want.granted_slot, got.granted_slot);
            compare_field("granted_class", want.granted_class, got.granted_class);
            compare_field("buffer_bytes", want.buffer_bytes, got.buffer_bytes);
            compare_field("granted_id", want.granted_id, got.granted_id);
            compare_field("free_count", want.free_count, got.free_count);
            compare_field("total_allocs", want.total_allocs, got.total_allocs);
            compare_field("failed_allocs", want.failed_allocs, got.failed_allocs);
            compare_field("in_use_count", want.in_use_count, got.in_use_count);
            compare_field("peak_in_use", want.peak_in_use, got.peak_in_use);
            compare_field("usage_count", want.usage_count, got.usage_count);
            compare_field("padding", want.pad, got.pad);
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_tuser = '0;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    pool_predictor pool = new();

    // Idling controls: percent of cycles the sender stays idle and the
    // receiver stalls. rx_held forces a long receiver stall.
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic rx_held = 1'b0;
    int   cycle_count = 0;
    event hold_off_kick;

    size_class_buffer_pool dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: random stalls, or a solid hold-off while rx_held is set.
    always @(posedge i_clk) begin
        i_m_tready <= !rx_held && ($urandom_range(99) >= stall_pct);
    end

    // The hold-off counts its own cycles so that the sender keeps offering
    // beats in the meantime; the block fills up and has to stall its input.
    initial begin
        forever begin
            @(hold_off_kick);
            rx_held <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_held <= 1'b0;
        end
    end

    // Every result beat taken by the receiver is checked against the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            pool.check_result(o_m_tdata);
    end

    // Watchdog: far above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offers one request beat and returns just after the edge at which it was
    // accepted. tvalid stays high on return, so back-to-back beats never see
    // it lowered and raised within the same time step.
    task automatic send_request(input pool_request_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'b0, req.id, req.slot, req.usage, req.want};
        i_s_tuser <= req.action;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        pool.note_request(req);
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic wait_results();
        i_s_tvalid <= 1'b0;
        while (pool.results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        pool.write_reg(idx, value);
    endtask

    // Register settings per phase: all classes code three with the smallest
    // sizes, all small with the largest sizes, a mix that holds every class
    // code, and a fully random setting. Called only with the block idle.
    task automatic configure(input int phase);
        logic [15:0] setting[4];
        case (phase)
            0: setting = '{16'hFFFF, 16'd1, 16'd1, 16'd1};
            1: setting = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            2: setting = '{16'hE41B, 16'($urandom_range(65535, 1)),
                           16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1))};
            default: setting = '{16'($urandom_range(65535)), 16'($urandom_range(65535, 1)),
                                 16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1))};
        endcase
        // The last result has left, but let the block settle before the writes.
        repeat (4) @(posedge i_clk);
        write_reg(CFG_SLOT_CLASSES, setting[0]);
        write_reg(CFG_SMALL_BYTES, setting[1]);
        write_reg(CFG_MEDIUM_BYTES, setting[2]);
        write_reg(CFG_LARGE_BYTES, setting[3]);
        i_cfg_we <= 1'b0;
    endtask

    function automatic pool_request_t make_request(t_action a, t_class w, logic [3:0] u,
                                                   logic [2:0] s, logic [31:0] id);
        pool_request_t req;
        req.action = a;
        req.want = w;
        req.usage = u;
        req.slot = s;
        req.id = id;
        return req;
    endfunction

    // Random traffic, mostly well formed: allocations and frees of live
    // handles keep the pool cycling between empty and full. The rest is stale
    // or blank handles, invalid classes, counts and statistics resets.
    // Fields an action ignores are random throughout.
    function automatic pool_request_t random_request();
        pool_request_t req;
        int pick;
        int busy_slots[$];
        req = make_request(ACT_COUNT, t_class'($urandom_range(3)), 4'($urandom_range(15)),
                           3'($urandom_range(7)), $urandom());
        pick = $urandom_range(99);
        for (int s = 0; s < NSLOTS; s++)
            if (pool.slot_busy[s])
                busy_slots.push_back(s);
        if (pick < 40) begin
            req.action = ACT_ALLOC;
            if ($urandom_range(19) != 0)
                req.want = t_class'($urandom_range(2));
        end else if (pick < 75) begin
            req.action = ACT_FREE;
            if (busy_slots.size() != 0) begin
                req.slot = 3'(busy_slots[$urandom_range(busy_slots.size() - 1)]);
                req.id = pool.slot_id[req.slot];
            end
        end else if (pick < 85) begin
            req.action = ACT_FREE;
            case ($urandom_range(2))
                0: req.id = '0;
                1: req.id = pool.slot_id[req.slot] ^ (32'h1 << $urandom_range(31));
                default: ;
            endcase
        end else if (pick < 96) begin
            req.action = ACT_COUNT;
        end else begin
            req.action = ACT_STATS;
        end
        return req;
    endfunction

    // Directed opening under the reset register values: slots 0 to 3 small,
    // 4 to 6 medium, 7 large.
    task automatic run_directed();
        // Counts for every class, the invalid one included.
        send_request(make_request(ACT_COUNT, CLS_SMALL, 4'd0, 3'd0, 32'h0));
        send_request(make_request(ACT_COUNT, CLS_MEDIUM, 4'd15, 3'd7, 32'hFFFF_FFFF));
        send_request(make_request(ACT_COUNT, CLS_LARGE, 4'd8, 3'd5, 32'hA5A5_5A5A));
        send_request(make_request(ACT_COUNT, CLS_INVALID, 4'd3, 3'd2, 32'h5A5A_A5A5));
        // Invalid class on allocate, then a free of an empty slot with the
        // blank id (double free) and with a wrong id (invalid argument).
        send_request(make_request(ACT_ALLOC, CLS_INVALID, 4'd1, 3'd0, 32'h0));
        send_request(make_request(ACT_FREE, CLS_SMALL, 4'd0, 3'd0, 32'h0));
        send_request(make_request(ACT_FREE, CLS_LARGE, 4'd0, 3'd7, 32'hFFFF_FFFF));
        // Fill the pool from the largest class down, with a refusal at each
        // step and usage tags both inside and outside the tallied range.
        send_request(make_request(ACT_ALLOC, CLS_LARGE, 4'd0, 3'd3, 32'h1));
        send_request(make_request(ACT_ALLOC, CLS_LARGE, 4'd15, 3'd4, 32'h2));
        for (int k = 0; k < 3; k++)
            send_request(make_request(ACT_ALLOC, CLS_MEDIUM, 4'd7, 3'(k), $urandom()));
        send_request(make_request(ACT_ALLOC, CLS_MEDIUM, 4'd7, 3'd1, $urandom()));
        for (int k = 0; k < 4; k++)
            send_request(make_request(ACT_ALLOC, CLS_SMALL, 4'd8, 3'(k), $urandom()));
        send_request(make_request(ACT_ALLOC, CLS_SMALL, 4'd2, 3'd6, $urandom()));
        send_request(make_request(ACT_STATS, CLS_SMALL, 4'd0, 3'd0, 32'h0));
        // Good free, repeated free with the now stale id, then the blank id.
        send_request(make_request(ACT_FREE, CLS_SMALL, 4'd0, 3'd7, pool.slot_id[7]));
        send_request(make_request(ACT_FREE, CLS_SMALL, 4'd0, 3'd7, 32'h1));
        send_request(make_request(ACT_FREE, CLS_SMALL, 4'd0, 3'd7, 32'h0));
        // Peak drops to the current in-use count.
        send_request(make_request(ACT_STATS, CLS_LARGE, 4'd15, 3'd7, 32'hFFFF_FFFF));
    endtask

    // The id wrap to one needs four billion grants and is out of reach here.
    initial begin
        int send_idle_by_phase[4] = '{0, 52, 0, 20};
        int stall_by_phase[4] = '{0, 0, 52, 20};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < 4; phase++) begin
            wait_results();
            configure(phase);
            send_idle_pct = send_idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while beats keep coming.
                if (n == 60)
                    -> hold_off_kick;
                // Sender pause until the pool has answered everything.
                if (n == 180)
                    wait_results();
                send_request(random_request());
            end
        end
        wait_results();
        repeat (8) @(posedge i_clk);
        if (pool.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
